FILE: hdl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types for the sliding median filter: the compare flags that each
// sort cell shows to its two neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

    typedef struct packed {
        logic above_new;   // cell value is greater than the incoming sample
        logic past_old;    // cell value is greater than or equal to the leaving sample
    } smf_flags_t;

endpackage

`default_nettype wire

FILE: hdl/smf_sample_if.sv
// ----------------------------------------------------------------------------
// smf_sample_if
// Valid/ready channel that carries one input sample per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_sample_if #(
    parameter int SAMPLE_WIDTH = 16
) ();

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

FILE: hdl/smf_median_if.sv
// ----------------------------------------------------------------------------
// smf_median_if
// Valid/ready channel that carries one median result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_median_if #(
    parameter int SAMPLE_WIDTH = 16
) ();

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);

endinterface

`default_nettype wire

FILE: hdl/smf_sort_cell.sv
// ----------------------------------------------------------------------------
// smf_sort_cell
// One cell of the sorted window. Holds one value; on each accepted beat it
// keeps its value, takes a neighbor's value or takes the new sample, so that
// the row stays sorted ascending after one copy of the leaving sample is
// dropped and the new sample is inserted.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_sort_cell #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift_en,
    input  wire logic signed [SAMPLE_WIDTH-1:0] new_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] old_sample,
    input  wire logic                           new_ge_old,
    input  wire logic signed [SAMPLE_WIDTH-1:0] left_value,
    input  wire logic signed [SAMPLE_WIDTH-1:0] right_value,
    input  wire smf_pkg::smf_flags_t            left_flags,
    input  wire smf_pkg::smf_flags_t            right_flags,
    output      smf_pkg::smf_flags_t            flags,
    output      logic signed [SAMPLE_WIDTH-1:0] value,
    output      logic signed [SAMPLE_WIDTH-1:0] value_next
);

    import smf_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] value_reg;

    always_comb
    begin
        flags.above_new = (value_reg > new_sample);
        flags.past_old  = (value_reg >= old_sample);
    end

    // leaving sample sits at or below the insertion point: slide down toward it
    // leaving sample sits above the insertion point: slide up toward it
    always_comb
    begin
        if (new_ge_old)
        begin
            if (flags.above_new || !flags.past_old)
                value_next = value_reg;
            else if (!right_flags.above_new)
                value_next = right_value;
            else
                value_next = new_sample;
        end
        else
        begin
            if (!flags.above_new)
                value_next = value_reg;
            else if (!left_flags.above_new)
                value_next = new_sample;
            else if (!left_flags.past_old)
                value_next = left_value;
            else
                value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else if (shift_en)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

FILE: hdl/sliding_median_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median over the last WINDOW_SIZE signed samples.
//
// Channels: samples (sink) takes one sample per beat; medians (source) gives
// one median per accepted sample, in order. Both are valid/ready; a beat
// moves when valid and ready are high at a rising clock edge.
// Output: a sample's median appears on medians in the cycle after its beat.
// Throughput: one sample per cycle while medians is not stalled. Each beat
// updates a row of WINDOW_SIZE sort cells, each cell deciding from its own
// two compares and its neighbors' flags; an arrival-order delay line names
// the sample that leaves the window.
// Stall: the median register holds while medians.ready is low; samples.ready
// stays high while that register is empty or is being drained in the same
// cycle, so a stalled receiver stops input after one waiting result.
// Reset: window and sorted row clear to zero at once, so early medians rank
// those zeros; no output is pending after reset.
// Median: the value at rank WINDOW_SIZE/2 of the ascending window (the upper
// middle value for an even window).
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter #(
    parameter int WINDOW_SIZE  = 9,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    smf_sample_if.sink   samples,
    smf_median_if.source medians
);

    import smf_pkg::*;

    localparam int MID = WINDOW_SIZE / 2;

    logic signed [SAMPLE_WIDTH-1:0] hist_reg [WINDOW_SIZE];
    logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_SIZE];
    logic signed [SAMPLE_WIDTH-1:0] cell_next  [WINDOW_SIZE];
    smf_flags_t                     cell_flags [WINDOW_SIZE];

    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] median_reg;
    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] old_sample;
    logic                           new_ge_old;

    assign samples.ready = !out_valid_reg || medians.ready;
    assign accept        = samples.valid && samples.ready;
    assign old_sample    = hist_reg[WINDOW_SIZE-1];
    assign new_ge_old    = (samples.sample >= old_sample);

    // advance the arrival-order line; the last tap is the sample that leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                hist_reg[i] <= '0;
        end
        else if (accept)
        begin
            hist_reg[0] <= samples.sample;
            for (int i = 1; i < WINDOW_SIZE; i++)
                hist_reg[i] <= hist_reg[i-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_SIZE; g++)
        begin : g_cell
            smf_flags_t                     left_flags;
            smf_flags_t                     right_flags;
            logic signed [SAMPLE_WIDTH-1:0] left_value;
            logic signed [SAMPLE_WIDTH-1:0] right_value;

            if (g == 0)
            begin : g_left_edge
                assign left_flags = '{above_new: 1'b0, past_old: 1'b0};
                assign left_value = cell_value[g];
            end
            else
            begin : g_left
                assign left_flags = cell_flags[g-1];
                assign left_value = cell_value[g-1];
            end

            if (g == WINDOW_SIZE - 1)
            begin : g_right_edge
                assign right_flags = '{above_new: 1'b1, past_old: 1'b1};
                assign right_value = cell_value[g];
            end
            else
            begin : g_right
                assign right_flags = cell_flags[g+1];
                assign right_value = cell_value[g+1];
            end

            smf_sort_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .shift_en    (accept),
                .new_sample  (samples.sample),
                .old_sample  (old_sample),
                .new_ge_old  (new_ge_old),
                .left_value  (left_value),
                .right_value (right_value),
                .left_flags  (left_flags),
                .right_flags (right_flags),
                .flags       (cell_flags[g]),
                .value       (cell_value[g]),
                .value_next  (cell_next[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (medians.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            median_reg <= cell_next[MID];
    end

    assign medians.valid  = out_valid_reg;
    assign medians.median = median_reg;

    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> medians.valid
    ) else $error("accepted sample produced no median");

    a_empty_means_ready: assert property (
        @(posedge clk) disable iff (!rst_n)
        !medians.valid |-> samples.ready
    ) else $error("input stalled with no pending median");

    a_median_tracks_row: assert property (
        @(posedge clk) disable iff (!rst_n)
        medians.valid |-> (medians.median == cell_value[MID])
    ) else $error("pending median differs from middle sort cell");

    a_row_sorted_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        cell_value[0] <= cell_value[WINDOW_SIZE-1]
    ) else $error("sorted row out of order");

endmodule

`default_nettype wire

FILE: tb/sv/median_window_checker.sv
// ----------------------------------------------------------------------------
// median_window_checker
// Watches the sample and median channels of the sliding median filter. Each
// sample beat updates a private copy of the window and queues the median of
// that window; each median beat is compared with the oldest queued value.
// ----------------------------------------------------------------------------
`default_nettype none

module median_window_checker #(
    parameter int WINDOW_SIZE  = 9,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           sample_valid,
    input  wire logic                           sample_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           median_valid,
    input  wire logic                           median_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] median,
    output int                                  mismatch_count,
    output int                                  outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    sample_t     window [WINDOW_SIZE];
    int unsigned oldest;
    sample_t     expected_medians [$];
    int          failures;

    function automatic sample_t window_median();
        sample_t ranked [WINDOW_SIZE];
        sample_t key;
        int      j;
        ranked = window;
        for (int i = 1; i < WINDOW_SIZE; i++)
        begin
            key = ranked[i];
            j = i - 1;
            while (j >= 0 && ranked[j] > key)
            begin
                ranked[j + 1] = ranked[j];
                j--;
            end
            ranked[j + 1] = key;
        end
        return ranked[WINDOW_SIZE / 2];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            foreach (window[i])
                window[i] = '0;
            oldest = 0;
            expected_medians.delete();
            failures = 0;
        end
        else
        begin
            if (median_valid && median_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: median beat %0d with nothing pending", $realtime, median);
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (median !== want)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%0t: median mismatch: expected %0d, got %0d",
                                     $realtime, want, median);
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                window[oldest] = sample;
                oldest = (oldest == WINDOW_SIZE - 1) ? 0 : oldest + 1;
                expected_medians.push_back(window_median());
            end
        end
        mismatch_count <= failures;
        outstanding    <= expected_medians.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/sliding_median_filter_test.sv
// ----------------------------------------------------------------------------
// sliding_median_filter_test
// Drives the sliding median filter with directed extremes, duplicate runs and
// ramps, then random samples, with random idling on both channels, a long
// receiver hold-off and a drain pause; the checker compares every median.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_SIZE  = 9;
    localparam int SAMPLE_WIDTH = 16;
    localparam int RANDOM_ITEMS = 850;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatch_count;
    int   outstanding;

    smf_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples ();
    smf_median_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) medians ();

    sliding_median_filter #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples),
        .medians(medians)
    );

    median_window_checker #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) median_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (samples.valid),
        .sample_ready  (samples.ready),
        .sample        (samples.sample),
        .median_valid  (medians.valid),
        .median_ready  (medians.ready),
        .median        (medians.median),
        .mismatch_count(mismatch_count),
        .outstanding   (outstanding)
    );

    always #6 clk = ~clk;

    function automatic sample_t pick_sample();
        sample_t value;
        case ($urandom_range(9))
            0:       value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: value = sample_t'($signed($urandom_range(8)) - 4);
            default: value = sample_t'($urandom);
        endcase
        return value;
    endfunction

    task automatic send_sample(input sample_t value, input bit gaps);
        while (gaps && $urandom_range(99) < 7)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid  <= 1'b1;
        samples.sample <= value;
        do
            @(posedge clk);
        while (!samples.ready);
    endtask

    initial
    begin
        sample_t directed [$];
        samples.valid  <= 1'b0;
        samples.sample <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8001,
                     16'sh7ffe, 16'sh0064, 16'sh0064, 16'sh0064, 16'sh0064, 16'sh0064,
                     16'shfffc, 16'shfffd, 16'shfffe, 16'shffff, 16'sh0000, 16'sh0001,
                     16'sh0002, 16'sh0003, 16'sh0004, 16'sh7fff, 16'sh8000, 16'sh7fff,
                     16'sh8000};
        foreach (directed[i])
            send_sample(directed[i], 1'b1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 600)
            begin
                samples.valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
            send_sample(pick_sample(), !(n >= 300 && n < 500));
        end
        samples.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        medians.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (medians.valid && medians.ready)
                taken++;
            if (!held && taken == 400)
            begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                medians.ready <= 1'b0;
            end
            else
                medians.ready <= (taken >= 100 && taken < 300) || ($urandom_range(99) >= 7);
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/smf_pkg.sv
hdl/smf_sample_if.sv
hdl/smf_median_if.sv
hdl/smf_sort_cell.sv
hdl/sliding_median_filter.sv
tb/sv/median_window_checker.sv
tb/sv/sliding_median_filter_test.sv
